// ----- src/gtts_pkg.sv -----
// Shared widths, register indexes and state encodings of the tile task sequencer.
`default_nettype none

package gtts_pkg;

  localparam int unsigned DIM_W     = 16;         // dimension, index and extent width
  localparam int unsigned NUM_W     = 32;         // tile number width
  localparam int unsigned DIV_W     = DIM_W + 1;  // ceil-division dividend width
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_TPG   = CFG_IDX_W'(4);

  // Tile count recompute sequencer
  typedef enum logic {
    SEQ_IDLE,
    SEQ_DIV
  } seq_state_e;

  // Which dimension the shared divider works on
  typedef enum logic [1:0] {
    DIV_ROWS,
    DIV_DEPTH,
    DIV_COLS
  } div_sel_e;

endpackage

`default_nettype wire

// ----- src/gtts_ceil_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module gtts_ceil_div import gtts_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [DIM_W-1:0] divisor_i,   // held stable while running
  output logic                  done_o,
  output logic [DIM_W-1:0]      quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIM_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [DIV_W-1:0] trial;
  logic [DIV_W-1:0] diff;
  logic             fits;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = CNT_W'(DIV_W);
      run_d = 1'b1;
    end else if (run_q) begin
      // remainder stays below the divisor, so it fits DIM_W bits
      rem_d = fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[DIM_W-1:0];

endmodule

`default_nettype wire

// ----- src/gemm_tile_task_sequencer_core.sv -----
// Top level: blocked matrix product tile task sequencer.
//
// Channel   Dir  Handshake                 Payload
// in        in   in_valid_i / in_ready_o   restart_i
// out       out  out_valid_o / out_ready_i tile indices, extents, tile numbers, group
// cfg       in   cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// One word in, at most one word out, one word per cycle sustained while the sink
// keeps up and no recompute runs: the walk counters advance in the cycle a word
// is taken and the task lands in the output register, which is refilled while the
// sink takes the previous one. After a register write one shared bit-serial divider
// rebuilds the tile counts ceil(total/side), three divisions of 17 steps each, with
// input held off meanwhile. Reset loads the register defaults and a fresh walk, no
// recompute needed. A stalled sink holds the output register.
`default_nettype none

module gemm_tile_task_sequencer_core import gtts_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DIM_W-1:0]     cfg_wdata_i,
  // input word
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 restart_i,
  // result word
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [DIM_W-1:0]          tile_row_o,
  output logic [DIM_W-1:0]          tile_col_o,
  output logic [DIM_W-1:0]          tile_depth_o,
  output logic [DIM_W-1:0]          rows_valid_o,
  output logic [DIM_W-1:0]          depth_valid_o,
  output logic [DIM_W-1:0]          cols_valid_o,
  output logic [NUM_W-1:0]          left_tile_o,
  output logic [NUM_W-1:0]          right_tile_o,
  output logic [NUM_W-1:0]          dest_tile_o,
  output logic [NUM_W-1:0]          group_index_o,
  output logic [DIM_W-1:0]          group_slot_o,
  output logic                      is_last_o
);

  // ---------------------------------------------------------------- config
  logic [DIM_W-1:0] rows_total_q, depth_total_q, cols_total_q, tile_side_q, tpg_q;
  logic             cfg_hit;

  always_comb begin
    unique case (cfg_idx_i)
      CFG_ROWS, CFG_DEPTH, CFG_COLS, CFG_SIDE, CFG_TPG: cfg_hit = cfg_we_i;
      default:                                          cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_total_q  <= DIM_W'(1);
      depth_total_q <= DIM_W'(1);
      cols_total_q  <= DIM_W'(1);
      tile_side_q   <= DIM_W'(1);
      tpg_q         <= DIM_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS:  rows_total_q  <= cfg_wdata_i;
        CFG_DEPTH: depth_total_q <= cfg_wdata_i;
        CFG_COLS:  cols_total_q  <= cfg_wdata_i;
        CFG_SIDE:  tile_side_q   <= cfg_wdata_i;
        CFG_TPG:   tpg_q         <= cfg_wdata_i;
        default: ;  // out-of-range index ignored
      endcase
    end
  end

  // ------------------------------------------------- tile count recompute
  seq_state_e       state_q, state_d;
  div_sel_e         sel_q, sel_d;
  logic             pend_q;
  logic             div_start, div_done, cnt_we;
  logic [DIV_W-1:0] div_total, dividend;
  logic [DIM_W-1:0] quotient;
  logic [DIM_W-1:0] n_rows_q, n_depth_q, n_cols_q;
  logic             busy;

  // next state
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (pend_q) begin
          state_d = SEQ_DIV;
          sel_d   = DIV_ROWS;
        end
      end
      SEQ_DIV: begin
        if (pend_q) begin
          sel_d = DIV_ROWS;  // fresh write: start over
        end else if (div_done) begin
          unique case (sel_q)
            DIV_ROWS:  sel_d = DIV_DEPTH;
            DIV_DEPTH: sel_d = DIV_COLS;
            default:   state_d = SEQ_IDLE;
          endcase
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    div_start = pend_q;
    cnt_we    = 1'b0;
    if (state_q == SEQ_DIV && div_done && !pend_q) begin
      cnt_we = 1'b1;
      if (sel_q != DIV_COLS) begin
        div_start = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (sel_d)
      DIV_ROWS:  div_total = {1'b0, rows_total_q};
      DIV_DEPTH: div_total = {1'b0, depth_total_q};
      default:   div_total = {1'b0, cols_total_q};
    endcase
  end

  // ceil(total/side) as floor((total + side - 1)/side)
  assign dividend = div_total + {1'b0, tile_side_q} - DIV_W'(1);

  gtts_ceil_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (tile_side_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SEQ_IDLE;
      sel_q     <= DIV_ROWS;
      pend_q    <= 1'b0;
      n_rows_q  <= DIM_W'(1);
      n_depth_q <= DIM_W'(1);
      n_cols_q  <= DIM_W'(1);
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      pend_q  <= cfg_hit;
      if (cnt_we) begin
        unique case (sel_q)
          DIV_ROWS:  n_rows_q  <= quotient;
          DIV_DEPTH: n_depth_q <= quotient;
          default:   n_cols_q  <= quotient;
        endcase
      end
    end
  end

  assign busy = pend_q || (state_q != SEQ_IDLE);

  // ----------------------------------------------------------- walk state
  // fresh_q: walk starts over at the next word (after reset or a register write)
  logic             fresh_q, fresh_d;
  logic             done_q, done_d;
  logic [DIM_W-1:0] row_q, row_d, col_q, col_d, dep_q, dep_d, slot_q, slot_d;
  logic [DIM_W-1:0] rrow_q, rrow_d, rcol_q, rcol_d, rdep_q, rdep_d;  // remaining extents
  logic [NUM_W-1:0] dest_q, dest_d, group_q, group_d;
  logic [NUM_W-1:0] lbase_q, lbase_d, rbase_q, rbase_d;  // i*Q and q*J

  logic             cur_fresh, cur_done;
  logic [DIM_W-1:0] cur_row, cur_col, cur_dep, cur_slot;
  logic [DIM_W-1:0] cur_rrow, cur_rcol, cur_rdep;
  logic [NUM_W-1:0] cur_dest, cur_group, cur_lbase, cur_rbase;
  logic             empty, emit, in_fire, out_fire;
  logic             last_col, last_row, last_dep, slot_wrap, cur_last;
  logic [DIM_W-1:0] tpg_eff;
  logic [DIM_W-1:0] ext_rows, ext_cols, ext_dep;

  assign cur_fresh = restart_i || fresh_q;
  assign cur_done  = cur_fresh ? 1'b0 : done_q;
  assign cur_row   = cur_fresh ? '0 : row_q;
  assign cur_col   = cur_fresh ? '0 : col_q;
  assign cur_dep   = cur_fresh ? '0 : dep_q;
  assign cur_slot  = cur_fresh ? '0 : slot_q;
  assign cur_dest  = cur_fresh ? '0 : dest_q;
  assign cur_group = cur_fresh ? '0 : group_q;
  assign cur_lbase = cur_fresh ? '0 : lbase_q;
  assign cur_rbase = cur_fresh ? '0 : rbase_q;
  assign cur_rrow  = cur_fresh ? rows_total_q  : rrow_q;
  assign cur_rcol  = cur_fresh ? cols_total_q  : rcol_q;
  assign cur_rdep  = cur_fresh ? depth_total_q : rdep_q;

  assign empty = (rows_total_q == '0) || (depth_total_q == '0) ||
                 (cols_total_q == '0) || (tile_side_q == '0);
  assign emit  = !cur_done && !empty;

  assign tpg_eff   = (tpg_q == '0) ? DIM_W'(1) : tpg_q;
  assign last_col  = ({1'b0, cur_col}  + DIV_W'(1)) == {1'b0, n_cols_q};
  assign last_row  = ({1'b0, cur_row}  + DIV_W'(1)) == {1'b0, n_rows_q};
  assign last_dep  = ({1'b0, cur_dep}  + DIV_W'(1)) == {1'b0, n_depth_q};
  assign slot_wrap = ({1'b0, cur_slot} + DIV_W'(1)) == {1'b0, tpg_eff};
  assign cur_last  = last_col && last_row && last_dep;

  assign ext_rows = (cur_rrow < tile_side_q) ? cur_rrow : tile_side_q;
  assign ext_cols = (cur_rcol < tile_side_q) ? cur_rcol : tile_side_q;
  assign ext_dep  = (cur_rdep < tile_side_q) ? cur_rdep : tile_side_q;

  logic out_valid_q;

  assign in_ready_o = !busy && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  always_comb begin
    fresh_d = fresh_q;
    done_d  = done_q;
    row_d   = row_q;
    col_d   = col_q;
    dep_d   = dep_q;
    slot_d  = slot_q;
    dest_d  = dest_q;
    group_d = group_q;
    lbase_d = lbase_q;
    rbase_d = rbase_q;
    rrow_d  = rrow_q;
    rcol_d  = rcol_q;
    rdep_d  = rdep_q;
    if (cfg_hit) begin
      fresh_d = 1'b1;
    end else if (in_fire) begin
      fresh_d = 1'b0;
      done_d  = cur_done || empty;
      row_d   = cur_row;
      col_d   = cur_col;
      dep_d   = cur_dep;
      slot_d  = cur_slot;
      dest_d  = cur_dest;
      group_d = cur_group;
      lbase_d = cur_lbase;
      rbase_d = cur_rbase;
      rrow_d  = cur_rrow;
      rcol_d  = cur_rcol;
      rdep_d  = cur_rdep;
      if (emit) begin
        dest_d  = cur_dest + NUM_W'(1);
        slot_d  = slot_wrap ? '0 : cur_slot + DIM_W'(1);
        group_d = slot_wrap ? cur_group + NUM_W'(1) : cur_group;
        if (!last_col) begin
          col_d  = cur_col + DIM_W'(1);
          rcol_d = cur_rcol - tile_side_q;
        end else begin
          col_d  = '0;
          rcol_d = cols_total_q;
          if (!last_row) begin
            row_d   = cur_row + DIM_W'(1);
            rrow_d  = cur_rrow - tile_side_q;
            lbase_d = cur_lbase + {{(NUM_W-DIM_W){1'b0}}, n_depth_q};
          end else begin
            // row-major pass over destination tiles done: next depth tile, or end of walk
            row_d   = '0;
            rrow_d  = rows_total_q;
            lbase_d = '0;
            dest_d  = '0;
            group_d = '0;
            slot_d  = '0;
            if (!last_dep) begin
              dep_d   = cur_dep + DIM_W'(1);
              rdep_d  = cur_rdep - tile_side_q;
              rbase_d = cur_rbase + {{(NUM_W-DIM_W){1'b0}}, n_cols_q};
            end else begin
              dep_d   = '0;
              rdep_d  = depth_total_q;
              rbase_d = '0;
              done_d  = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b1;
      done_q  <= 1'b0;
      row_q   <= '0;
      col_q   <= '0;
      dep_q   <= '0;
      slot_q  <= '0;
      dest_q  <= '0;
      group_q <= '0;
      lbase_q <= '0;
      rbase_q <= '0;
      rrow_q  <= DIM_W'(1);
      rcol_q  <= DIM_W'(1);
      rdep_q  <= DIM_W'(1);
    end else begin
      fresh_q <= fresh_d;
      done_q  <= done_d;
      row_q   <= row_d;
      col_q   <= col_d;
      dep_q   <= dep_d;
      slot_q  <= slot_d;
      dest_q  <= dest_d;
      group_q <= group_d;
      lbase_q <= lbase_d;
      rbase_q <= rbase_d;
      rrow_q  <= rrow_d;
      rcol_q  <= rcol_d;
      rdep_q  <= rdep_d;
    end
  end

  // ------------------------------------------------------ output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      tile_row_o    <= cur_row;
      tile_col_o    <= cur_col;
      tile_depth_o  <= cur_dep;
      rows_valid_o  <= ext_rows;
      depth_valid_o <= ext_dep;
      cols_valid_o  <= ext_cols;
      left_tile_o   <= cur_lbase + {{(NUM_W-DIM_W){1'b0}}, cur_dep};
      right_tile_o  <= cur_rbase + {{(NUM_W-DIM_W){1'b0}}, cur_col};
      dest_tile_o   <= cur_dest;
      group_index_o <= cur_group;
      group_slot_o  <= cur_slot;
      is_last_o     <= cur_last;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // no word taken while tile counts are being rebuilt
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> !in_ready_o)
    else $error("input taken during tile count recompute");

  // slot stays inside its group once the walk is under way
  assert property (@(posedge clk_i) disable iff (!rst_ni) !fresh_q |-> slot_q < tpg_eff)
    else $error("group slot out of range");

  // final task closes the walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && emit && cur_last && !cfg_hit) |=> (done_q && out_valid_o && is_last_o))
    else $error("walk not closed after last task");
`endif

endmodule

`default_nettype wire

// ----- dv/gtts_task_checker.sv -----
`timescale 1ns / 100ps
// Tile task checker: predicts each task word from the input and config traffic and compares.
module gtts_task_checker import gtts_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DIM_W-1:0]     cfg_wdata_i,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_ready_i,
  input  wire logic                 restart_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_ready_i,
  input  wire logic [DIM_W-1:0]     tile_row_i,
  input  wire logic [DIM_W-1:0]     tile_col_i,
  input  wire logic [DIM_W-1:0]     tile_depth_i,
  input  wire logic [DIM_W-1:0]     rows_valid_i,
  input  wire logic [DIM_W-1:0]     depth_valid_i,
  input  wire logic [DIM_W-1:0]     cols_valid_i,
  input  wire logic [NUM_W-1:0]     left_tile_i,
  input  wire logic [NUM_W-1:0]     right_tile_i,
  input  wire logic [NUM_W-1:0]     dest_tile_i,
  input  wire logic [NUM_W-1:0]     group_index_i,
  input  wire logic [DIM_W-1:0]     group_slot_i,
  input  wire logic                 is_last_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  typedef struct packed {
    logic [DIM_W-1:0] tile_row;
    logic [DIM_W-1:0] tile_col;
    logic [DIM_W-1:0] tile_depth;
    logic [DIM_W-1:0] rows_valid;
    logic [DIM_W-1:0] depth_valid;
    logic [DIM_W-1:0] cols_valid;
    logic [NUM_W-1:0] left_tile;
    logic [NUM_W-1:0] right_tile;
    logic [NUM_W-1:0] dest_tile;
    logic [NUM_W-1:0] group_index;
    logic [DIM_W-1:0] group_slot;
    logic             is_last;
  } tile_task_t;

  tile_task_t expected_tasks[$];

  logic [DIM_W-1:0] rows_total, depth_total, cols_total, tile_side, tiles_per_group;
  logic [DIM_W-1:0] q_cnt, i_cnt, j_cnt, slot_cnt;
  logic [NUM_W-1:0] dest_cnt, group_cnt;
  logic             walk_done;

  function automatic void rewind_walk();
    q_cnt     = '0;
    i_cnt     = '0;
    j_cnt     = '0;
    slot_cnt  = '0;
    dest_cnt  = '0;
    group_cnt = '0;
    walk_done = 1'b0;
  endfunction

  function automatic int unsigned tiles_along(input logic [DIM_W-1:0] total);
    return (32'(total) + 32'(tile_side) - 32'd1) / 32'(tile_side);
  endfunction

  // unpadded extent of tile idx: min(side, total - idx*side)
  function automatic logic [DIM_W-1:0] tile_extent(input logic [DIM_W-1:0] total,
                                                   input logic [DIM_W-1:0] idx);
    int unsigned rest;
    rest = 32'(total) - 32'(idx) * 32'(tile_side);
    return (rest < 32'(tile_side)) ? rest[DIM_W-1:0] : tile_side;
  endfunction

  // one accepted input word: emit the current task (if any) and step the walk
  function automatic void plan_step(input logic restart);
    int unsigned ni, nq, nj, tpg;
    tile_task_t t;
    if (restart) rewind_walk();
    if (walk_done) return;
    if (rows_total == '0 || depth_total == '0 || cols_total == '0 || tile_side == '0) begin
      walk_done = 1'b1;
      return;
    end
    ni  = tiles_along(rows_total);
    nq  = tiles_along(depth_total);
    nj  = tiles_along(cols_total);
    tpg = (tiles_per_group == '0) ? 32'd1 : 32'(tiles_per_group);

    t.tile_row    = i_cnt;
    t.tile_col    = j_cnt;
    t.tile_depth  = q_cnt;
    t.rows_valid  = tile_extent(rows_total, i_cnt);
    t.depth_valid = tile_extent(depth_total, q_cnt);
    t.cols_valid  = tile_extent(cols_total, j_cnt);
    t.left_tile   = 32'(i_cnt) * nq + 32'(q_cnt);
    t.right_tile  = 32'(q_cnt) * nj + 32'(j_cnt);
    t.dest_tile   = dest_cnt;
    t.group_index = group_cnt;
    t.group_slot  = slot_cnt;
    t.is_last     = (32'(q_cnt) + 1 == nq) && (32'(i_cnt) + 1 == ni) && (32'(j_cnt) + 1 == nj);
    expected_tasks.insert(expected_tasks.size(), t);

    dest_cnt = dest_cnt + 1'b1;
    slot_cnt = slot_cnt + 1'b1;
    if (32'(slot_cnt) >= tpg) begin
      slot_cnt  = '0;
      group_cnt = group_cnt + 1'b1;
    end
    j_cnt = j_cnt + 1'b1;
    if (32'(j_cnt) >= nj) begin
      j_cnt = '0;
      i_cnt = i_cnt + 1'b1;
      if (32'(i_cnt) >= ni) begin
        i_cnt     = '0;
        dest_cnt  = '0;
        group_cnt = '0;
        slot_cnt  = '0;
        q_cnt     = q_cnt + 1'b1;
        if (32'(q_cnt) >= nq) begin
          q_cnt     = '0;
          walk_done = 1'b1;
        end
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [NUM_W-1:0] want,
                                      input logic [NUM_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tile_task_t want;
    if (!rst_ni) begin
      rows_total      = 16'd1;
      depth_total     = 16'd1;
      cols_total      = 16'd1;
      tile_side       = 16'd1;
      tiles_per_group = 16'd1;
      fail_count_o    = 0;
      rewind_walk();
      expected_tasks.delete();
    end else begin
      // result side first: a word taken this edge cannot be the one just sent
      if (out_valid_i && out_ready_i) begin
        if (expected_tasks.size() == 0) begin
          $error("result word with none expected: tile (%0d,%0d,%0d)",
                 tile_row_i, tile_col_i, tile_depth_i);
          fail_count_o++;
        end else begin
          want = expected_tasks.pop_front();
          check_field("tile_row", NUM_W'(want.tile_row), NUM_W'(tile_row_i));
          check_field("tile_col", NUM_W'(want.tile_col), NUM_W'(tile_col_i));
          check_field("tile_depth", NUM_W'(want.tile_depth), NUM_W'(tile_depth_i));
          check_field("rows_valid", NUM_W'(want.rows_valid), NUM_W'(rows_valid_i));
          check_field("depth_valid", NUM_W'(want.depth_valid), NUM_W'(depth_valid_i));
          check_field("cols_valid", NUM_W'(want.cols_valid), NUM_W'(cols_valid_i));
          check_field("left_tile", want.left_tile, left_tile_i);
          check_field("right_tile", want.right_tile, right_tile_i);
          check_field("dest_tile", want.dest_tile, dest_tile_i);
          check_field("group_index", want.group_index, group_index_i);
          check_field("group_slot", NUM_W'(want.group_slot), NUM_W'(group_slot_i));
          check_field("is_last", NUM_W'(want.is_last), NUM_W'(is_last_i));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROWS:  begin rows_total      = cfg_wdata_i; rewind_walk(); end
          CFG_DEPTH: begin depth_total     = cfg_wdata_i; rewind_walk(); end
          CFG_COLS:  begin cols_total      = cfg_wdata_i; rewind_walk(); end
          CFG_SIDE:  begin tile_side       = cfg_wdata_i; rewind_walk(); end
          CFG_TPG:   begin tiles_per_group = cfg_wdata_i; rewind_walk(); end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) plan_step(restart_i);
    end
    pending_o = expected_tasks.size();
  end

endmodule

// ----- dv/tb_gemm_tile_task_sequencer_core.sv -----
`timescale 1ns / 100ps
// Testbench top for the tile task sequencer: stimulus, configuration phases and verdict.
module tb_gemm_tile_task_sequencer_core;
  import gtts_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int IDLE_PCT      = 26;     // chance per cycle that a side idles
  localparam int HOLD_CYCLES   = 300;    // long sink stall to back the block up
  localparam int SETTLE_CYCLES = 64;     // covers the tile count rebuild
  localparam int TARGET_TASKS  = 1100;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int MAX_PHASE_LEN = 150;

  localparam logic [DIM_W-1:0]     DIM_MAX          = '1;
  // indexes past the last register: writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_TPG + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = '1;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [DIM_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 restart_i   = 1'b0;
  logic                 out_ready_i = 1'b0;

  wire logic             in_ready_o;
  wire logic             out_valid_o;
  wire logic [DIM_W-1:0] tile_row_o, tile_col_o, tile_depth_o;
  wire logic [DIM_W-1:0] rows_valid_o, depth_valid_o, cols_valid_o;
  wire logic [NUM_W-1:0] left_tile_o, right_tile_o, dest_tile_o, group_index_o;
  wire logic [DIM_W-1:0] group_slot_o;
  wire logic             is_last_o;

  int fail_count;
  int pending;

  // shared with the sink process: idle-free stretch and stall requests
  bit no_idle  = 1'b0;
  int hold_req = 0;

  gemm_tile_task_sequencer_core u_top (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .restart_i,
    .out_valid_o, .out_ready_i,
    .tile_row_o, .tile_col_o, .tile_depth_o,
    .rows_valid_o, .depth_valid_o, .cols_valid_o,
    .left_tile_o, .right_tile_o, .dest_tile_o,
    .group_index_o, .group_slot_o, .is_last_o
  );

  gtts_task_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .restart_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .tile_row_i(tile_row_o), .tile_col_i(tile_col_o), .tile_depth_i(tile_depth_o),
    .rows_valid_i(rows_valid_o), .depth_valid_i(depth_valid_o),
    .cols_valid_i(cols_valid_o),
    .left_tile_i(left_tile_o), .right_tile_i(right_tile_o), .dest_tile_i(dest_tile_o),
    .group_index_i(group_index_o), .group_slot_i(group_slot_o), .is_last_i(is_last_o),
    .fail_count_o(fail_count),
    .pending_o(pending)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  // Sink: random back-pressure, a clean stretch on request, and one long
  // hold-off counted here so the sender keeps pushing into a full block.
  initial begin : sink
    int served;
    served = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != served) begin
        served = hold_req;
        repeat (HOLD_CYCLES) begin
          out_ready_i <= 1'b0;
          @(negedge clk_i);
        end
      end else if (no_idle) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Offer one input word; returns on the edge it is taken. Valid stays up
  // into the next call unless that call idles first.
  task automatic issue_step(input logic restart);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      restart_i  <= 1'($urandom_range(0, 1));
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // stop offering, let every expected word out, then leave room for the
  // divider rebuild and any word still in flight
  task automatic quiesce();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    quiesce();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic load_plan(input logic [DIM_W-1:0] m, input logic [DIM_W-1:0] k,
                           input logic [DIM_W-1:0] n, input logic [DIM_W-1:0] side,
                           input logic [DIM_W-1:0] tpg);
    write_register(CFG_ROWS, m);
    write_register(CFG_DEPTH, k);
    write_register(CFG_COLS, n);
    write_register(CFG_SIDE, side);
    write_register(CFG_TPG, tpg);
  endtask

  // mostly a few tiles per dimension, now and then zero, full scale or any value
  function automatic logic [DIM_W-1:0] pick_total(input logic [DIM_W-1:0] side);
    int unsigned r, hi;
    r  = $urandom_range(0, 19);
    hi = 32'(side) * 6;
    if (hi == 0 || hi > 32'(DIM_MAX)) hi = 32'(DIM_MAX);
    if (r == 0) return '0;
    if (r == 1) return DIM_MAX;
    if (r == 2) return DIM_W'($urandom_range(1, 32'(DIM_MAX)));
    return DIM_W'($urandom_range(1, hi));
  endfunction

  function automatic longint walk_length(input logic [DIM_W-1:0] m, input logic [DIM_W-1:0] k,
                                         input logic [DIM_W-1:0] n, input logic [DIM_W-1:0] side);
    if (m == '0 || k == '0 || n == '0 || side == '0) return 0;
    return ((longint'(m) + side - 1) / side) * ((longint'(k) + side - 1) / side) *
           ((longint'(n) + side - 1) / side);
  endfunction

  initial begin : stimulus
    int               tasks_done, phase, words, r, waited;
    longint           walk_len;
    logic             noisy;
    logic [DIM_W-1:0] m, k, n, side, tpg;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part.
    // Reset defaults: a single-tile walk, a step past its end, then restart.
    issue_step(1'b0);
    issue_step(1'b0);
    issue_step(1'b1);

    // Ragged edge tiles (3x2x2 tiles) with zero tiles per group read as one;
    // a write to an unused index mid-walk must leave the walk where it was.
    load_plan(16'd7, 16'd5, 16'd4, 16'd3, 16'd0);
    repeat (5) issue_step(1'b0);
    write_register(CFG_FIRST_UNUSED, 16'd3);
    repeat (8) issue_step(1'b0);

    // Zero rows: nothing comes out, restart or not.
    write_register(CFG_ROWS, '0);
    issue_step(1'b0);
    issue_step(1'b1);

    // Full-scale registers: one huge tile, then unit tiles on a huge matrix.
    load_plan(DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX);
    issue_step(1'b0);
    load_plan(DIM_MAX, DIM_MAX, DIM_MAX, 16'd1, DIM_MAX);
    issue_step(1'b0);
    issue_step(1'b0);

    // Random phases: mostly whole walks, some with restarts sprinkled in,
    // some running past the end of the walk.
    tasks_done = 0;
    phase      = 0;
    while (tasks_done < TARGET_TASKS) begin
      if (phase < 2) begin
        // long walks: sink hold-off first, then the idle-free stretch
        side = 16'd8;
        m    = 16'd40;
        k    = 16'd40;
        n    = 16'd40;
        tpg  = 16'd5;
      end else begin
        r = $urandom_range(0, 19);
        if (r == 0)      side = '0;
        else if (r == 1) side = DIM_MAX;
        else if (r < 4)  side = DIM_W'($urandom_range(9, 32'(DIM_MAX)));
        else             side = DIM_W'($urandom_range(1, 8));
        m = pick_total(side);
        k = pick_total(side);
        n = pick_total(side);
        r = $urandom_range(0, 9);
        if (r == 0)      tpg = '0;
        else if (r == 1) tpg = DIM_MAX;
        else             tpg = DIM_W'($urandom_range(1, 12));
      end
      load_plan(m, k, n, side, tpg);
      if ($urandom_range(0, 3) == 0)
        write_register(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
                       DIM_W'($urandom));

      walk_len = walk_length(m, k, n, side);
      if (walk_len == 0)
        words = $urandom_range(2, 4);
      else
        words = int'((walk_len < MAX_PHASE_LEN) ? walk_len : MAX_PHASE_LEN) +
                $urandom_range(0, 3);
      noisy   = ($urandom_range(0, 4) == 0);
      no_idle = (phase == 1);
      if (phase == 0) hold_req++;

      for (int w = 0; w < words; w++) begin
        if (noisy) issue_step(1'($urandom_range(0, 99) < 30));
        else       issue_step(1'($urandom_range(0, 99) < 3));
      end
      tasks_done += int'((words < walk_len) ? words : walk_len);
      no_idle = 1'b0;
      phase++;
    end

    // Drain and verdict.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (16) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      if (pending != 0) $error("%0d result words never arrived", pending);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/gtts_pkg.sv
src/gtts_ceil_div.sv
src/gemm_tile_task_sequencer_core.sv
dv/gtts_task_checker.sv
dv/tb_gemm_tile_task_sequencer_core.sv
